FILE: rtl/utf8d_pkg.sv
// shared types, constants and lead byte decode for the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned QDepth = 4;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StEnd       = 3'd1,
    StPremature = 3'd2,
    StStray     = 3'd3,
    StBadLead   = 3'd4,
    StInvalid   = 3'd5,
    StFault     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       source_fault;
  } item_t;

  typedef struct packed {
    logic           vld;
    logic [CpW-1:0] cp;
    status_e        st;
    logic           last;
  } res_t;

  typedef struct packed {
    logic           emit;
    logic [CpW-1:0] cp;
    status_e        st;
    logic           open;
    logic [CpW-1:0] pv;
    logic [1:0]     br;
  } lead_t;

  function automatic lead_t decode_lead(input logic [7:0] b);
    lead_t l;
    l = '0;
    if (!b[7]) begin
      l.emit = 1'b1;
      l.cp   = CpW'(b);
      l.st   = StOk;
    end else if (!b[6]) begin
      l.emit = 1'b1;
      l.st   = StStray;
    end else if (!b[5]) begin
      l.open = 1'b1;
      l.pv   = CpW'(b[4:0]);
      l.br   = 2'd1;
    end else if (!b[4]) begin
      l.open = 1'b1;
      l.pv   = CpW'(b[3:0]);
      l.br   = 2'd2;
    end else if (!b[3]) begin
      l.open = 1'b1;
      l.pv   = CpW'(b[2:0]);
      l.br   = 2'd3;
    end else begin
      l.emit = 1'b1;
      l.st   = StBadLead;
    end
    return l;
  endfunction

endpackage

FILE: rtl/utf8d_decode.sv
// sequence state and single-pass decode of one registered byte into up to two results
module utf8d_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  utf8d_pkg::item_t item_i,
  output utf8d_pkg::res_t  res0_o,
  output utf8d_pkg::res_t  res1_o
);

  logic [utf8d_pkg::CpW-1:0] pv_q, pv_d, pv_sh;
  logic [1:0]                br_q, br_d;
  utf8d_pkg::lead_t          lead;
  utf8d_pkg::res_t           r0, r1;

  always_comb begin
    lead  = utf8d_pkg::decode_lead(item_i.data_byte);
    pv_sh = {pv_q[utf8d_pkg::CpW-7:0], item_i.data_byte[5:0]};
    r0    = '0;
    r1    = '0;
    pv_d  = pv_q;
    br_d  = br_q;
    if (item_i.source_fault) begin
      r0.vld = 1'b1;
      r0.st  = utf8d_pkg::StFault;
      pv_d   = '0;
      br_d   = '0;
    end else if (item_i.end_of_stream) begin
      r0.vld = 1'b1;
      r0.st  = (br_q != 2'd0) ? utf8d_pkg::StPremature : utf8d_pkg::StEnd;
      pv_d   = '0;
      br_d   = '0;
    end else if (br_q != 2'd0) begin
      if (item_i.data_byte[7:6] == 2'b10) begin
        br_d = br_q - 2'd1;
        if (br_q == 2'd1) begin
          r0.vld = 1'b1;
          r0.cp  = pv_sh;
          r0.st  = utf8d_pkg::StOk;
          pv_d   = '0;
        end else begin
          pv_d = pv_sh;
        end
      end else begin
        // bad continuation closes the sequence, then the byte is retried as a lead
        r0.vld = 1'b1;
        r0.st  = utf8d_pkg::StInvalid;
        pv_d   = '0;
        br_d   = '0;
        r1.vld = lead.emit;
        r1.cp  = lead.cp;
        r1.st  = lead.st;
        if (lead.open) begin
          pv_d = lead.pv;
          br_d = lead.br;
        end
      end
    end else begin
      r0.vld = lead.emit;
      r0.cp  = lead.cp;
      r0.st  = lead.st;
      if (lead.open) begin
        pv_d = lead.pv;
        br_d = lead.br;
      end
    end
    r1.last = r1.vld;
    r0.last = r0.vld & ~r1.vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      br_q <= '0;
    end else if (fire_i) begin
      pv_q <= pv_d;
      br_q <= br_d;
    end
  end

  assign res0_o = r0;
  assign res1_o = r1;

  a_second_after_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r1.vld |-> (r0.vld && r0.st == utf8d_pkg::StInvalid))
    else $error("second result without an invalid continuation first");

  a_no_value_unless_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r0.vld && r0.st != utf8d_pkg::StOk) |-> (r0.cp == '0))
    else $error("code point set on a result that is not ok");

  a_fault_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.source_fault) |=> (br_q == 2'd0 && pv_q == '0))
    else $error("sequence still open after a source fault");

endmodule

FILE: rtl/utf8d_res_queue.sv
// result queue taking up to two results per cycle and delivering one per transaction
module utf8d_res_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  utf8d_pkg::res_t res0_i,
  input  utf8d_pkg::res_t res1_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output utf8d_pkg::res_t head_o
);

  localparam int unsigned PtrW = $clog2(utf8d_pkg::QDepth);
  localparam int unsigned CntW = $clog2(utf8d_pkg::QDepth + 1);

  utf8d_pkg::res_t mem_q [utf8d_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_p1;
  logic [CntW-1:0] count_q, count_d;
  logic            push0, push1, pop;
  logic [1:0]      push_n;

  always_comb begin
    push0    = wr_en_i & res0_i.vld;
    push1    = wr_en_i & res1_i.vld;
    pop      = out_valid_o & out_ready_i;
    push_n   = {1'b0, push0} + {1'b0, push1};
    wr_p1    = wr_ptr_q + PtrW'(1);
    wr_ptr_d = wr_ptr_q + PtrW'(push_n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push0) begin
      mem_q[wr_ptr_q] <= res0_i;
    end
    if (push1) begin
      mem_q[wr_p1] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign room_o      = (count_q <= CntW'(utf8d_pkg::QDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i |-> room_o)
    else $error("results written without two free entries");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(utf8d_pkg::QDepth))
    else $error("result queue count out of range");

endmodule

FILE: rtl/utf8_stream_decoder_top.sv
// top level of the utf-8 stream decoder: input register, decode and result queue
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | sink      | in_valid_i / in_ready_o | data_byte_i, end_of_stream_i, source_fault_i
//  out     | source    | out_valid_o/out_ready_i | code_point_o, status_o, last_of_run_o
//
// one input byte per cycle while the result queue has room; a byte is decoded from the input register
// its results are written into the result queue and leave it one result per output transaction
// the input register advances while the four-entry result queue has two free entries
// so only a byte giving two results, or output stalls, hold the input back
// rst_ni clears the sequence state, the input register's valid flag and the queue; no clearing pass
module utf8_stream_decoder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      end_of_stream_i,
  input  logic                      source_fault_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [utf8d_pkg::CpW-1:0] code_point_o,
  output logic [2:0]                status_o,
  output logic                      last_of_run_o
);

  utf8d_pkg::item_t in_item_q;
  logic             in_vld_q, in_vld_d;
  logic             fire, room, in_acc;
  utf8d_pkg::res_t  res0, res1, head;

  assign fire       = in_vld_q & room;
  assign in_ready_o = ~in_vld_q | fire;
  assign in_acc     = in_valid_i & in_ready_o;
  assign in_vld_d   = in_acc | (in_vld_q & ~fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_item_q <= '{data_byte: data_byte_i, end_of_stream: end_of_stream_i,
                     source_fault: source_fault_i};
    end
  end

  utf8d_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item_q),
    .res0_o (res0),
    .res1_o (res1)
  );

  utf8d_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (fire),
    .res0_i      (res0),
    .res1_i      (res1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign code_point_o  = head.cp;
  assign status_o      = head.st;
  assign last_of_run_o = head.last;

endmodule
